@@ design/bra_pkg.sv @@
// bra_pkg: shared types and constants for the best rational approximation block
// used by bra_csr, bra_ctrl, bra_dp and best_rational_approximation
package bra_pkg;

   // width of the signed numerator on the result channel
   localparam int NUM_OUT_W = 32;

   // register reset values
   localparam int MAX_DEN_RESET = 10000;
   localparam int TOL_RESET     = 17;

   // register index, taken from the top address bit
   localparam logic REG_MAX_DEN = 1'b0;
   localparam logic REG_TOL     = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic load;          // capture a new item and set the bounds to 0/1 and 1/0
      logic step;          // move one bound onto the mediant
      logic mul_lower;     // product for the lower bound error
      logic mul_upper;     // product for the upper bound error
      logic take_mediant;  // result is the mediant, stopped on tolerance
      logic take_lower;    // result is the lower bound
      logic take_closer;   // result is the closer of the two bounds
      logic emit;          // load the output register
   } bra_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic den_over;   // mediant denominator exceeds the maximum
      logic hit;        // mediant lies within the tolerance
      logic upper_inf;  // upper bound is still 1/0
   } bra_stat_type;

endpackage

@@ design/best_rational_approximation.sv @@
// best_rational_approximation: top level, best rational approximation of a fixed-point value
// instantiates bra_csr, bra_ctrl and bra_dp; depends on bra_pkg
//
// Input channel req_: one item is a magnitude in unsigned Q(INT_BITS).(FRAC_BITS) and a
// sign bit. Result channel rsp_: one item per input, the signed numerator, the positive
// denominator and a flag that is 1 when the walk stopped on the tolerance.
// CSRs on csr_: denominator limit at byte address 0, tolerance at 4 (8 on a 64-bit bus).
// Each walk cycle forms one mediant and moves one bound; the walk unit is the only
// loop. With k mediants inside the limit (k <= integer part + denominator limit) the
// walk stops: on the tolerance the mediant is taken; when the limit is reached while
// the upper bound is still 1/0 the lower bound is taken; else the closer bound is picked
// by the shared multiplier (two products, one compare). The result then waits for a
// free output register. A new item is accepted at the earliest in the cycle after the
// result is loaded into the output register, so the block takes no new item before it
// is through with the last one. The output register holds a finished result while the
// receiver stalls; a new item is then already accepted and walked, and waits for the
// register to free up. Reset returns the controller to idle, drops rsp_valid and loads a
// denominator limit of 10000 and a tolerance of 17.
module best_rational_approximation
   import bra_pkg::*;
#(
   parameter int DEN_BITS  = 14,
   parameter int FRAC_BITS = 24,
   parameter int INT_BITS  = 16,
   localparam int CSR_DATA_W = (FRAC_BITS + 1 > 32) ? 64 : 32,
   localparam int CSR_ADDR_W = (CSR_DATA_W == 64) ? 4 : 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [INT_BITS+FRAC_BITS-1:0] req_value_magnitude,
   input  logic                          req_value_negative,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [NUM_OUT_W-1:0]   rsp_numerator,
   output logic [DEN_BITS-1:0]           rsp_denominator,
   output logic                          rsp_within_tolerance,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [CSR_DATA_W-1:0]         csr_pwdata,
   output logic [CSR_DATA_W-1:0]         csr_prdata,
   output logic                          csr_pready
);

   logic [DEN_BITS-1:0] max_den;
   logic [FRAC_BITS:0]  tol;
   bra_cmd_type         cmd;
   bra_stat_type        stat;

   bra_csr #(
      .DEN_BITS   (DEN_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .CSR_DATA_W (CSR_DATA_W),
      .CSR_ADDR_W (CSR_ADDR_W)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_den     (max_den),
      .tol         (tol)
   );

   bra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bra_dp #(
      .DEN_BITS  (DEN_BITS),
      .FRAC_BITS (FRAC_BITS),
      .INT_BITS  (INT_BITS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .max_den              (max_den),
      .tol                  (tol),
      .req_value_magnitude  (req_value_magnitude),
      .req_value_negative   (req_value_negative),
      .rsp_numerator        (rsp_numerator),
      .rsp_denominator      (rsp_denominator),
      .rsp_within_tolerance (rsp_within_tolerance)
   );

endmodule

@@ design/bra_csr.sv @@
// bra_csr: configuration registers on an apb-style port
// depends on bra_pkg for reset values and register indexes
module bra_csr
   import bra_pkg::*;
#(
   parameter int DEN_BITS   = 14,
   parameter int FRAC_BITS  = 24,
   parameter int CSR_DATA_W = 32,
   parameter int CSR_ADDR_W = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [DEN_BITS-1:0]   max_den,
   output logic [FRAC_BITS:0]    tol
);

   localparam int TOL_W = FRAC_BITS + 1;

   logic                wr_en;
   logic                reg_sel;
   logic [DEN_BITS-1:0] max_den_ff;
   logic [TOL_W-1:0]    tol_ff;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[CSR_ADDR_W-1];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_den_ff <= DEN_BITS'(MAX_DEN_RESET);
         tol_ff     <= TOL_W'(TOL_RESET);
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_MAX_DEN: max_den_ff <= csr_pwdata[DEN_BITS-1:0];
            REG_TOL:     tol_ff     <= csr_pwdata[TOL_W-1:0];
            default:     ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_MAX_DEN: csr_prdata = CSR_DATA_W'(max_den_ff);
         REG_TOL:     csr_prdata = CSR_DATA_W'(tol_ff);
         default:     csr_prdata = '0;
      endcase
   end

   assign max_den = max_den_ff;
   assign tol     = tol_ff;

endmodule

@@ design/bra_ctrl.sv @@
// bra_ctrl: sequencer for the stern-brocot walk and the result handshake
// depends on bra_pkg for the command and status structs
module bra_ctrl
   import bra_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  bra_stat_type stat,
   output bra_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_MUL_L,
      S_MUL_U,
      S_PICK,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            priority if (stat.den_over) begin
               if (stat.upper_inf) begin
                  cmd.take_lower = 1'b1;
                  state_in       = S_FINISH;
               end else begin
                  state_in = S_MUL_L;
               end
            end else if (stat.hit) begin
               cmd.take_mediant = 1'b1;
               state_in         = S_FINISH;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_MUL_L: begin
            cmd.mul_lower = 1'b1;
            state_in      = S_MUL_U;
         end
         S_MUL_U: begin
            cmd.mul_upper = 1'b1;
            state_in      = S_PICK;
         end
         S_PICK: begin
            cmd.take_closer = 1'b1;
            state_in        = S_FINISH;
         end
         S_FINISH: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && rsp_valid_ff && !rsp_ready) |=> (state_ff == S_FINISH))
      else $error("result overwritten while the output register is held");

endmodule

@@ design/bra_dp.sv @@
// bra_dp: bounds, scaled errors and tolerance products for the walk, final compare
// and output register; depends on bra_pkg for the command and status structs
module bra_dp
   import bra_pkg::*;
#(
   parameter int DEN_BITS  = 14,
   parameter int FRAC_BITS = 24,
   parameter int INT_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bra_cmd_type                   cmd,
   output bra_stat_type                  stat,
   input  logic [DEN_BITS-1:0]           max_den,
   input  logic [FRAC_BITS:0]            tol,
   input  logic [INT_BITS+FRAC_BITS-1:0] req_value_magnitude,
   input  logic                          req_value_negative,
   output logic signed [NUM_OUT_W-1:0]   rsp_numerator,
   output logic [DEN_BITS-1:0]           rsp_denominator,
   output logic                          rsp_within_tolerance
);

   localparam int VAL_W = INT_BITS + FRAC_BITS;
   localparam int TOL_W = FRAC_BITS + 1;
   localparam int NUM_W = INT_BITS + DEN_BITS + 2;
   localparam int D_W   = DEN_BITS + 1;
   localparam int T_W   = TOL_W + DEN_BITS;
   localparam int TS_W  = T_W + 1;
   localparam int E_W   = VAL_W + 1;
   localparam int CMP_W = (VAL_W > TS_W) ? VAL_W : TS_W;
   localparam int P_W   = TOL_W + DEN_BITS;
   localparam int RES_W = (NUM_W > NUM_OUT_W) ? NUM_W : NUM_OUT_W;

   // bounds ln/ld and un/ud with el = v*ld - ln*2^f, eu = un*2^f - v*ud,
   // tl = tol*ld, tu = tol*ud, all kept by additions only
   logic                 neg_ff;
   logic [NUM_W-1:0]     ln_ff, un_ff;
   logic [DEN_BITS-1:0]  ld_ff, ud_ff;
   logic [VAL_W-1:0]     el_ff;
   logic [TOL_W-1:0]     eu_ff;
   logic [T_W-1:0]       tl_ff, tu_ff;
   logic [P_W-1:0]       prod_l_ff, prod_u_ff;
   logic [NUM_W-1:0]     res_num_ff;
   logic [DEN_BITS-1:0]  res_den_ff;
   logic                 res_hit_ff;
   logic signed [NUM_OUT_W-1:0] rsp_numerator_ff;
   logic [DEN_BITS-1:0]  rsp_denominator_ff;
   logic                 rsp_within_ff;

   logic [NUM_W-1:0]     med_num;
   logic [D_W-1:0]       med_den;
   logic [E_W-1:0]       e_diff, e_rdiff;
   logic                 med_below;
   logic [VAL_W-1:0]     e_mag;
   logic [TS_W-1:0]      t_sum;
   logic [TOL_W-1:0]     mul_a;
   logic [DEN_BITS-1:0]  mul_b;
   logic [P_W-1:0]       prod;
   logic                 closer_lower;
   logic [RES_W-1:0]     num_ext, num_signed;
   logic [TOL_W-1:0]     one_fix;

   assign one_fix = TOL_W'(1) << FRAC_BITS;

   // mediant and its signed scaled error v*d - m*2^f = el - eu
   assign med_num   = ln_ff + un_ff;
   assign med_den   = D_W'(ld_ff) + D_W'(ud_ff);
   assign e_diff    = E_W'(el_ff) - E_W'(eu_ff);
   assign e_rdiff   = E_W'(eu_ff) - E_W'(el_ff);
   assign med_below = !e_diff[E_W-1] && (e_diff != '0);
   assign e_mag     = e_diff[E_W-1] ? e_rdiff[VAL_W-1:0] : e_diff[VAL_W-1:0];
   assign t_sum     = TS_W'(tl_ff) + TS_W'(tu_ff);

   assign stat.den_over  = med_den > D_W'(max_den);
   assign stat.hit       = CMP_W'(e_mag) < CMP_W'(t_sum);
   assign stat.upper_inf = (ud_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff <= req_value_negative;
         ln_ff  <= '0;
         ld_ff  <= DEN_BITS'(1);
         un_ff  <= NUM_W'(1);
         ud_ff  <= '0;
         el_ff  <= req_value_magnitude;
         eu_ff  <= one_fix;
         tl_ff  <= T_W'(tol);
         tu_ff  <= '0;
      end else if (cmd.step) begin
         if (med_below) begin
            ln_ff <= med_num;
            ld_ff <= med_den[DEN_BITS-1:0];
            el_ff <= e_diff[VAL_W-1:0];
            tl_ff <= t_sum[T_W-1:0];
         end else begin
            un_ff <= med_num;
            ud_ff <= med_den[DEN_BITS-1:0];
            eu_ff <= e_rdiff[TOL_W-1:0];
            tu_ff <= t_sum[T_W-1:0];
         end
      end
   end

   // one shared multiplier: el*ud then eu*ld; both errors stay within 2^f once bracketed
   assign mul_a = cmd.mul_upper ? eu_ff : el_ff[TOL_W-1:0];
   assign mul_b = cmd.mul_upper ? ld_ff : ud_ff;
   assign prod  = P_W'(mul_a) * P_W'(mul_b);

   always_ff @(posedge clock) begin
      if (cmd.mul_lower) begin
         prod_l_ff <= prod;
      end
      if (cmd.mul_upper) begin
         prod_u_ff <= prod;
      end
   end

   // tie goes to the upper bound
   assign closer_lower = prod_l_ff < prod_u_ff;

   always_ff @(posedge clock) begin
      priority if (cmd.take_mediant) begin
         res_num_ff <= med_num;
         res_den_ff <= med_den[DEN_BITS-1:0];
         res_hit_ff <= 1'b1;
      end else if (cmd.take_lower || (cmd.take_closer && closer_lower)) begin
         res_num_ff <= ln_ff;
         res_den_ff <= ld_ff;
         res_hit_ff <= 1'b0;
      end else if (cmd.take_closer) begin
         res_num_ff <= un_ff;
         res_den_ff <= ud_ff;
         res_hit_ff <= 1'b0;
      end
   end

   assign num_ext    = RES_W'(res_num_ff);
   assign num_signed = neg_ff ? (RES_W'(0) - num_ext) : num_ext;

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_numerator_ff   <= num_signed[NUM_OUT_W-1:0];
         rsp_denominator_ff <= res_den_ff;
         rsp_within_ff      <= res_hit_ff;
      end
   end

   assign rsp_numerator        = rsp_numerator_ff;
   assign rsp_denominator      = rsp_denominator_ff;
   assign rsp_within_tolerance = rsp_within_ff;

   a_bracket_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_lower |-> (el_ff <= VAL_W'(one_fix)) && (ud_ff != '0))
      else $error("lower error exceeds one unit while both bounds are finite");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.emit) |-> (rsp_denominator_ff != '0))
      else $error("emitted item has a zero denominator");

endmodule
